// ===== rtl/one_wire_bus_master_assert.svh =====
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Clocked implication checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OWB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("one-wire master check failed");

// next-cycle implication, sampled on clk, off during reset
`define OWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("one-wire master check failed");

`endif

// ===== rtl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master package
// Request and result types, command codes, phase encoding and register map.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] write_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_byte;
  } out_item_t;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_RST_PRE  = 11'b000_0000_0010,
    PH_RST_LOW  = 11'b000_0000_0100,
    PH_RST_WAIT = 11'b000_0000_1000,
    PH_RST_TAIL = 11'b000_0001_0000,
    PH_WR_LOW   = 11'b000_0010_0000,
    PH_WR_HOLD  = 11'b000_0100_0000,
    PH_WR_REC   = 11'b000_1000_0000,
    PH_RD_LOW   = 11'b001_0000_0000,
    PH_RD_WAIT  = 11'b010_0000_0000,
    PH_RD_TAIL  = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WRITE_LOW     = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_TAIL     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] reset_tail_ticks;
    logic [CFG_W-1:0] write_low_ticks;
    logic [CFG_W-1:0] write_hold_ticks;
    logic [CFG_W-1:0] read_low_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
    logic [CFG_W-1:0] read_tail_ticks;
  } cfg_regs_t;

  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 11'd551;
  localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 11'd81;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 11'd418;
  localparam logic [CFG_W-1:0] RST_WRITE_LOW     = 11'd2;
  localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 11'd80;
  localparam logic [CFG_W-1:0] RST_READ_LOW      = 11'd3;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 11'd3;
  localparam logic [CFG_W-1:0] RST_READ_TAIL     = 11'd50;

endpackage

// ===== rtl/owb_cfg.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master timing registers
// Eight slot-length registers written through the configuration port.
// ----------------------------------------------------------------------------
module owb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [owb_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [owb_pkg::CFG_W-1:0]           wr_data,
  output owb_pkg::cfg_regs_t                  regs
);

  owb_pkg::cfg_regs_t regs_r;
  owb_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (owb_pkg::cfg_idx_t'(wr_index))
        owb_pkg::REG_RESET_LOW:     regs_nxt.reset_low_ticks     = wr_data;
        owb_pkg::REG_PRESENCE_WAIT: regs_nxt.presence_wait_ticks = wr_data;
        owb_pkg::REG_RESET_TAIL:    regs_nxt.reset_tail_ticks    = wr_data;
        owb_pkg::REG_WRITE_LOW:     regs_nxt.write_low_ticks     = wr_data;
        owb_pkg::REG_WRITE_HOLD:    regs_nxt.write_hold_ticks    = wr_data;
        owb_pkg::REG_READ_LOW:      regs_nxt.read_low_ticks      = wr_data;
        owb_pkg::REG_READ_SAMPLE:   regs_nxt.read_sample_ticks   = wr_data;
        owb_pkg::REG_READ_TAIL:     regs_nxt.read_tail_ticks     = wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low_ticks     <= owb_pkg::RST_RESET_LOW;
      regs_r.presence_wait_ticks <= owb_pkg::RST_PRESENCE_WAIT;
      regs_r.reset_tail_ticks    <= owb_pkg::RST_RESET_TAIL;
      regs_r.write_low_ticks     <= owb_pkg::RST_WRITE_LOW;
      regs_r.write_hold_ticks    <= owb_pkg::RST_WRITE_HOLD;
      regs_r.read_low_ticks      <= owb_pkg::RST_READ_LOW;
      regs_r.read_sample_ticks   <= owb_pkg::RST_READ_SAMPLE;
      regs_r.read_tail_ticks     <= owb_pkg::RST_READ_TAIL;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/owb_ctrl.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master slot sequencer
// Phase state machine, tick counter and bit shifter; one request per cycle.
// ----------------------------------------------------------------------------
module owb_ctrl #(
  parameter int RESET_PREAMBLE_TICKS = 3,
  parameter int WRITE_RECOVERY_TICKS = 2,
  parameter int TICK_COUNT_BITS      = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  owb_pkg::in_item_t   item,
  input  owb_pkg::cfg_regs_t  cfg,
  output owb_pkg::out_item_t  res
);

  localparam int CMP_W = (TICK_COUNT_BITS > owb_pkg::CFG_W) ? TICK_COUNT_BITS : owb_pkg::CFG_W;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << TICK_COUNT_BITS) - 1);
  localparam logic [CMP_W-1:0] PRE_LEN = CMP_W'(RESET_PREAMBLE_TICKS);
  localparam logic [CMP_W-1:0] REC_LEN = CMP_W'(WRITE_RECOVERY_TICKS);
  localparam owb_pkg::phase_t RST_ENTRY =
    (RESET_PREAMBLE_TICKS > 0) ? owb_pkg::PH_RST_PRE : owb_pkg::PH_RST_LOW;

  owb_pkg::phase_t              phase_r,    phase_nxt;
  logic [TICK_COUNT_BITS-1:0]   tick_r,     tick_nxt;
  logic [2:0]                   bit_r,      bit_nxt;
  logic [7:0]                   shift_r,    shift_nxt;
  logic                         pres_r,     pres_nxt;

  logic [TICK_COUNT_BITS-1:0]   cnt_inc;
  logic [CMP_W-1:0]             len_raw;
  logic [CMP_W-1:0]             len;
  logic                         phase_end;
  logic                         done;
  logic                         present;
  logic [7:0]                   rb;

  always_comb begin
    unique case (phase_r)
      owb_pkg::PH_RST_PRE:  len_raw = PRE_LEN;
      owb_pkg::PH_RST_LOW:  len_raw = CMP_W'(cfg.reset_low_ticks);
      owb_pkg::PH_RST_WAIT: len_raw = CMP_W'(cfg.presence_wait_ticks);
      owb_pkg::PH_RST_TAIL: len_raw = CMP_W'(cfg.reset_tail_ticks);
      owb_pkg::PH_WR_LOW:   len_raw = CMP_W'(cfg.write_low_ticks);
      owb_pkg::PH_WR_HOLD:  len_raw = CMP_W'(cfg.write_hold_ticks);
      owb_pkg::PH_WR_REC:   len_raw = REC_LEN;
      owb_pkg::PH_RD_LOW:   len_raw = CMP_W'(cfg.read_low_ticks);
      owb_pkg::PH_RD_WAIT:  len_raw = CMP_W'(cfg.read_sample_ticks);
      owb_pkg::PH_RD_TAIL:  len_raw = CMP_W'(cfg.read_tail_ticks);
      default:              len_raw = CMP_W'(1);
    endcase
    if (len_raw == '0) begin
      len = CMP_W'(1);
    end else if (len_raw > CNT_MAX) begin
      len = CNT_MAX;
    end else begin
      len = len_raw;
    end
    cnt_inc   = (&tick_r) ? tick_r : tick_r + 1'b1;
    phase_end = CMP_W'(cnt_inc) >= len;
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    done      = 1'b0;
    present   = 1'b0;
    rb        = '0;
    if (item_valid) begin
      if (phase_r == owb_pkg::PH_IDLE) begin
        unique case (item.cmd)
          owb_pkg::CMD_RESET: begin
            pres_nxt  = 1'b0;
            shift_nxt = '0;
            bit_nxt   = '0;
            phase_nxt = RST_ENTRY;
            tick_nxt  = '0;
          end
          owb_pkg::CMD_WRITE: begin
            shift_nxt = item.write_byte;
            bit_nxt   = '0;
            phase_nxt = owb_pkg::PH_WR_LOW;
            tick_nxt  = '0;
          end
          owb_pkg::CMD_READ: begin
            shift_nxt = '0;
            bit_nxt   = '0;
            phase_nxt = owb_pkg::PH_RD_LOW;
            tick_nxt  = '0;
          end
          default: ;
        endcase
      end else if (item.cmd == owb_pkg::CMD_TICK) begin
        tick_nxt = cnt_inc;
        if (phase_end) begin
          tick_nxt = '0;
          unique case (phase_r)
            owb_pkg::PH_RST_PRE:  phase_nxt = owb_pkg::PH_RST_LOW;
            owb_pkg::PH_RST_LOW:  phase_nxt = owb_pkg::PH_RST_WAIT;
            owb_pkg::PH_RST_WAIT: begin
              pres_nxt  = !item.line_level;
              phase_nxt = owb_pkg::PH_RST_TAIL;
            end
            owb_pkg::PH_RST_TAIL: begin
              present   = pres_r && item.line_level;
              done      = 1'b1;
              phase_nxt = owb_pkg::PH_IDLE;
            end
            owb_pkg::PH_WR_LOW:   phase_nxt = owb_pkg::PH_WR_HOLD;
            owb_pkg::PH_WR_HOLD:  phase_nxt = owb_pkg::PH_WR_REC;
            owb_pkg::PH_WR_REC: begin
              shift_nxt = {1'b0, shift_r[7:1]};
              if (&bit_r) begin
                bit_nxt   = '0;
                done      = 1'b1;
                phase_nxt = owb_pkg::PH_IDLE;
              end else begin
                bit_nxt   = bit_r + 1'b1;
                phase_nxt = owb_pkg::PH_WR_LOW;
              end
            end
            owb_pkg::PH_RD_LOW:   phase_nxt = owb_pkg::PH_RD_WAIT;
            owb_pkg::PH_RD_WAIT: begin
              shift_nxt = {item.line_level, shift_r[7:1]};
              phase_nxt = owb_pkg::PH_RD_TAIL;
            end
            owb_pkg::PH_RD_TAIL: begin
              if (&bit_r) begin
                bit_nxt   = '0;
                done      = 1'b1;
                rb        = shift_r;
                phase_nxt = owb_pkg::PH_IDLE;
              end else begin
                bit_nxt   = bit_r + 1'b1;
                phase_nxt = owb_pkg::PH_RD_LOW;
              end
            end
            default: phase_nxt = owb_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  always_comb begin
    res.drive_low = (phase_nxt == owb_pkg::PH_RST_LOW) ||
                    (phase_nxt == owb_pkg::PH_WR_LOW)  ||
                    (phase_nxt == owb_pkg::PH_RD_LOW)  ||
                    ((phase_nxt == owb_pkg::PH_WR_HOLD) && !shift_nxt[0]);
    res.busy_res       = phase_nxt != owb_pkg::PH_IDLE;
    res.done_res       = done;
    res.device_present = present;
    res.read_byte      = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owb_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// A request accepted into the request register passes through the sequencer, and its
// result is registered in the output register, which drives the output port.
// Throughput: one request per cycle, set by the single-pass sequencer; a stalled
// result holds the request register, which then stalls the input.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears both
// stages and loads the default slot timings.
// ----------------------------------------------------------------------------
// One-wire bus master
// Reset/presence, write-byte and read-byte slot generator driven by ticks.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int RESET_PREAMBLE_TICKS = 3,
  parameter int WRITE_RECOVERY_TICKS = 2,
  parameter int TICK_COUNT_BITS      = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  owb_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output owb_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owb_pkg::CFG_W-1:0]      cfg_data
);

  logic                in_valid_r;
  owb_pkg::in_item_t   in_data_r;
  logic                out_valid_r;
  owb_pkg::out_item_t  out_data_r;
  logic                advance;
  owb_pkg::cfg_regs_t  cfg_regs;
  owb_pkg::out_item_t  res;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  owb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  owb_ctrl #(
    .RESET_PREAMBLE_TICKS (RESET_PREAMBLE_TICKS),
    .WRITE_RECOVERY_TICKS (WRITE_RECOVERY_TICKS),
    .TICK_COUNT_BITS      (TICK_COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r && advance),
    .item       (in_data_r),
    .cfg        (cfg_regs),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/owb_checker.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master port checker
// Result consistency and output hold checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "one_wire_bus_master_assert.svh"

module owb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input owb_pkg::out_item_t  out_data
);

  `OWB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `OWB_ASSERT_NOW(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res)
  `OWB_ASSERT_NOW(a_present_done, out_valid && out_data.device_present, out_data.done_res)
  `OWB_ASSERT_NOW(a_drive_busy, out_valid && out_data.drive_low, out_data.busy_res)

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master testbench
// Drives reset/presence, write-byte and read-byte sequences tick by tick with
// random gaps on both channels, and checks every result item against a
// scoreboard that tracks the slot sequencer, across default, minimum and
// random slot timings.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREAMBLE_TICKS = 3;
  localparam int RECOVERY_TICKS = 2;
  localparam int COUNT_BITS     = 11;
  localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
  localparam int NUM_REGS       = 8;
  localparam int STALL_LIMIT    = 500;
  localparam int RANDOM_ITEMS   = 150;
  localparam int RANDOM_DONES   = 6;
  localparam int SEQS_PER_SETUP = 3;

  class owb_scoreboard;
    logic [owb_pkg::CFG_W-1:0] slot_len [NUM_REGS];
    owb_pkg::phase_t           phase;
    logic [COUNT_BITS-1:0]     ticks;
    logic [2:0]                bit_idx;
    logic [7:0]                shreg;
    logic                      pres;
    owb_pkg::out_item_t        bus_results_due [$];
    int                        errors;
    int                        done_count;
    int                        live_count;

    function new();
      slot_len[owb_pkg::REG_RESET_LOW]     = owb_pkg::RST_RESET_LOW;
      slot_len[owb_pkg::REG_PRESENCE_WAIT] = owb_pkg::RST_PRESENCE_WAIT;
      slot_len[owb_pkg::REG_RESET_TAIL]    = owb_pkg::RST_RESET_TAIL;
      slot_len[owb_pkg::REG_WRITE_LOW]     = owb_pkg::RST_WRITE_LOW;
      slot_len[owb_pkg::REG_WRITE_HOLD]    = owb_pkg::RST_WRITE_HOLD;
      slot_len[owb_pkg::REG_READ_LOW]      = owb_pkg::RST_READ_LOW;
      slot_len[owb_pkg::REG_READ_SAMPLE]   = owb_pkg::RST_READ_SAMPLE;
      slot_len[owb_pkg::REG_READ_TAIL]     = owb_pkg::RST_READ_TAIL;
      phase      = owb_pkg::PH_IDLE;
      ticks      = '0;
      bit_idx    = '0;
      shreg      = '0;
      pres       = 1'b0;
      errors     = 0;
      done_count = 0;
      live_count = 0;
    endfunction

    function void write_reg(owb_pkg::cfg_idx_t idx, logic [owb_pkg::CFG_W-1:0] v);
      slot_len[idx] = v;
    endfunction

    function int phase_len(owb_pkg::phase_t p);
      int n;
      case (p)
        owb_pkg::PH_RST_PRE:  n = PREAMBLE_TICKS;
        owb_pkg::PH_RST_LOW:  n = int'(slot_len[owb_pkg::REG_RESET_LOW]);
        owb_pkg::PH_RST_WAIT: n = int'(slot_len[owb_pkg::REG_PRESENCE_WAIT]);
        owb_pkg::PH_RST_TAIL: n = int'(slot_len[owb_pkg::REG_RESET_TAIL]);
        owb_pkg::PH_WR_LOW:   n = int'(slot_len[owb_pkg::REG_WRITE_LOW]);
        owb_pkg::PH_WR_HOLD:  n = int'(slot_len[owb_pkg::REG_WRITE_HOLD]);
        owb_pkg::PH_WR_REC:   n = RECOVERY_TICKS;
        owb_pkg::PH_RD_LOW:   n = int'(slot_len[owb_pkg::REG_READ_LOW]);
        owb_pkg::PH_RD_WAIT:  n = int'(slot_len[owb_pkg::REG_READ_SAMPLE]);
        owb_pkg::PH_RD_TAIL:  n = int'(slot_len[owb_pkg::REG_READ_TAIL]);
        default:              n = 1;
      endcase
      if (n == 0) n = 1;
      if (n > COUNT_MAX) n = COUNT_MAX;
      return n;
    endfunction

    function void enter_phase(owb_pkg::phase_t p);
      phase = p;
      ticks = '0;
    endfunction

    function void note_request(owb_pkg::in_item_t req);
      owb_pkg::out_item_t res;
      res = '0;
      if (phase == owb_pkg::PH_IDLE) begin
        live_count++;
        case (req.cmd)
          owb_pkg::CMD_RESET: begin
            pres    = 1'b0;
            shreg   = '0;
            bit_idx = '0;
            if (PREAMBLE_TICKS > 0) enter_phase(owb_pkg::PH_RST_PRE);
            else enter_phase(owb_pkg::PH_RST_LOW);
          end
          owb_pkg::CMD_WRITE: begin
            shreg   = req.write_byte;
            bit_idx = '0;
            enter_phase(owb_pkg::PH_WR_LOW);
          end
          owb_pkg::CMD_READ: begin
            shreg   = '0;
            bit_idx = '0;
            enter_phase(owb_pkg::PH_RD_LOW);
          end
          default: ;
        endcase
      end else if (req.cmd == owb_pkg::CMD_TICK) begin
        live_count++;
        if (int'(ticks) < COUNT_MAX) ticks++;
        if (int'(ticks) >= phase_len(phase)) begin
          case (phase)
            owb_pkg::PH_RST_PRE: enter_phase(owb_pkg::PH_RST_LOW);
            owb_pkg::PH_RST_LOW: enter_phase(owb_pkg::PH_RST_WAIT);
            owb_pkg::PH_RST_WAIT: begin
              pres = !req.line_level;
              enter_phase(owb_pkg::PH_RST_TAIL);
            end
            owb_pkg::PH_RST_TAIL: begin
              res.device_present = pres & req.line_level;
              res.done_res       = 1'b1;
              enter_phase(owb_pkg::PH_IDLE);
            end
            owb_pkg::PH_WR_LOW:  enter_phase(owb_pkg::PH_WR_HOLD);
            owb_pkg::PH_WR_HOLD: enter_phase(owb_pkg::PH_WR_REC);
            owb_pkg::PH_WR_REC: begin
              shreg = shreg >> 1;
              if (bit_idx >= 3'd7) begin
                bit_idx      = '0;
                res.done_res = 1'b1;
                enter_phase(owb_pkg::PH_IDLE);
              end else begin
                bit_idx++;
                enter_phase(owb_pkg::PH_WR_LOW);
              end
            end
            owb_pkg::PH_RD_LOW: enter_phase(owb_pkg::PH_RD_WAIT);
            owb_pkg::PH_RD_WAIT: begin
              shreg = {req.line_level, shreg[7:1]};
              enter_phase(owb_pkg::PH_RD_TAIL);
            end
            owb_pkg::PH_RD_TAIL: begin
              if (bit_idx >= 3'd7) begin
                bit_idx       = '0;
                res.done_res  = 1'b1;
                res.read_byte = shreg;
                enter_phase(owb_pkg::PH_IDLE);
              end else begin
                bit_idx++;
                enter_phase(owb_pkg::PH_RD_LOW);
              end
            end
            default: enter_phase(owb_pkg::PH_IDLE);
          endcase
        end
      end
      case (phase)
        owb_pkg::PH_RST_LOW, owb_pkg::PH_WR_LOW, owb_pkg::PH_RD_LOW: res.drive_low = 1'b1;
        owb_pkg::PH_WR_HOLD: res.drive_low = !shreg[0];
        default:             res.drive_low = 1'b0;
      endcase
      res.busy_res = (phase != owb_pkg::PH_IDLE);
      if (res.done_res) done_count++;
      bus_results_due.push_back(res);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(owb_pkg::out_item_t got);
      owb_pkg::out_item_t want;
      if (bus_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        return;
      end
      want = bus_results_due.pop_front();
      check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("device_present", 8'(want.device_present), 8'(got.device_present));
      check_field("read_byte", want.read_byte, got.read_byte);
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  owb_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  owb_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [owb_pkg::CFG_W-1:0]     cfg_data  = '0;

  owb_scoreboard sb;
  bit            calm        = 1'b0;
  int            quiet_count = 0;

  one_wire_bus_master #(
    .RESET_PREAMBLE_TICKS(PREAMBLE_TICKS),
    .WRITE_RECOVERY_TICKS(RECOVERY_TICKS),
    .TICK_COUNT_BITS     (COUNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap();
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (calm) return 0;
    return int'($urandom_range(0, 17));
  endfunction

  function automatic logic [owb_pkg::CFG_W-1:0] pick_len();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return '0;
    if (r <= 7) return owb_pkg::CFG_W'($urandom_range(1, 3));
    return owb_pkg::CFG_W'($urandom_range(4, 8));
  endfunction

  task automatic send_request(input owb_pkg::in_item_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic send_tick(input logic line);
    owb_pkg::in_item_t req;
    req.cmd        = owb_pkg::CMD_TICK;
    req.write_byte = 8'($urandom);
    req.line_level = line;
    send_request(req);
  endtask

  task automatic run_sequence(input logic [1:0] cmd, input logic [7:0] wbyte,
                              input logic [7:0] rd_bits, input logic present_low,
                              input logic tail_high, input int noise_pct);
    owb_pkg::in_item_t req;
    req.cmd        = cmd;
    req.write_byte = wbyte;
    req.line_level = 1'($urandom_range(0, 1));
    send_request(req);
    while (sb.phase != owb_pkg::PH_IDLE) begin
      req.write_byte = 8'($urandom);
      if (int'($urandom_range(0, 99)) < noise_pct) begin
        req.cmd        = 2'($urandom_range(1, 3));
        req.line_level = 1'($urandom_range(0, 1));
      end else begin
        req.cmd = owb_pkg::CMD_TICK;
        case (sb.phase)
          owb_pkg::PH_RST_WAIT: req.line_level = !present_low;
          owb_pkg::PH_RST_TAIL: req.line_level = tail_high;
          owb_pkg::PH_RD_WAIT:  req.line_level = rd_bits[sb.bit_idx];
          default:              req.line_level = 1'($urandom_range(0, 1));
        endcase
      end
      send_request(req);
    end
  endtask

  task automatic random_sequence(input int noise_pct);
    int n;
    int k;
    if ($urandom_range(0, 4) == 0) begin
      n = int'($urandom_range(1, 3));
      for (k = 0; k < n; k++) send_tick(1'($urandom_range(0, 1)));
    end
    run_sequence(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), noise_pct);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.bus_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [owb_pkg::CFG_W-1:0] vals [NUM_REGS]);
    int                first;
    int                k;
    owb_pkg::cfg_idx_t idx;
    first = int'($urandom_range(0, NUM_REGS - 1));
    for (k = 0; k < NUM_REGS; k++) begin
      idx = owb_pkg::cfg_idx_t'((first + k) % NUM_REGS);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, vals[idx]);
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_count <= 0;
      end else if (quiet_count >= STALL_LIMIT) begin
        $display("** one_wire_bus_master: FAILED **");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [owb_pkg::CFG_W-1:0] regs [NUM_REGS];
    int                        k;
    int                        setup;
    int                        item_base;
    int                        done_base;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default slot timings straight out of reset
    run_sequence(owb_pkg::CMD_READ, 8'h00, 8'($urandom), 1'b0, 1'b0, 0);
    drain_results();

    for (k = 0; k < NUM_REGS; k++) regs[k] = owb_pkg::CFG_W'(1);
    program_regs(regs);
    send_tick(1'b0);
    send_tick(1'b1);
    run_sequence(owb_pkg::CMD_RESET, 8'h00, 8'h00, 1'b1, 1'b1, 0);
    run_sequence(owb_pkg::CMD_RESET, 8'hFF, 8'h00, 1'b0, 1'b1, 0);
    run_sequence(owb_pkg::CMD_RESET, 8'h00, 8'h00, 1'b1, 1'b0, 0);
    run_sequence(owb_pkg::CMD_RESET, 8'h00, 8'h00, 1'b0, 1'b0, 30);
    run_sequence(owb_pkg::CMD_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 0);
    run_sequence(owb_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0, 0);
    run_sequence(owb_pkg::CMD_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0, 30);
    run_sequence(owb_pkg::CMD_READ, 8'h3C, 8'h00, 1'b0, 1'b0, 0);
    run_sequence(owb_pkg::CMD_READ, 8'h00, 8'hFF, 1'b0, 1'b0, 0);
    run_sequence(owb_pkg::CMD_READ, 8'hC3, 8'h5A, 1'b0, 1'b0, 30);
    drain_results();

    item_base = sb.live_count;
    done_base = sb.done_count;
    setup     = 0;
    while (sb.live_count - item_base < RANDOM_ITEMS || sb.done_count - done_base < RANDOM_DONES) begin
      for (k = 0; k < NUM_REGS; k++) regs[k] = (setup == 0) ? '0 : pick_len();
      program_regs(regs);
      for (k = 0; k < SEQS_PER_SETUP; k++) random_sequence(4);
      drain_results();
      setup++;
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.bus_results_due.size() == 0) begin
      $display("** one_wire_bus_master: PASSED **");
    end else begin
      $display("** one_wire_bus_master: FAILED **");
    end
    $finish;
  end

endmodule
